[rtl/thfd_pkg.sv]
package thfd_pkg;

  // crc-8 used by the sensor: polynomial 0x31, start value 0xff, no final xor
  localparam logic [7:0] CRC_POLY = 8'h31;
  localparam logic [7:0] CRC_INIT = 8'hFF;

  // position of a word within the six-word frame
  localparam logic [2:0] POS_TEMP_HI  = 3'd0;
  localparam logic [2:0] POS_TEMP_LO  = 3'd1;
  localparam logic [2:0] POS_TEMP_CRC = 3'd2;
  localparam logic [2:0] POS_HUMI_HI  = 3'd3;
  localparam logic [2:0] POS_HUMI_LO  = 3'd4;
  localparam logic [2:0] POS_HUMI_CRC = 3'd5;

  // scaling constants
  localparam logic [14:0]        TEMP_GAIN   = 15'd17500;
  localparam logic [13:0]        HUMI_GAIN   = 14'd10000;
  localparam logic signed [31:0] TEMP_OFFSET = 32'sd294907500;  // 4500 * 65535
  localparam logic [16:0]        FULL_SCALE  = 17'd65535;

  // default depth of the queue between front and back
  localparam int QUEUE_DEPTH_DEFAULT = 2;

  // one complete frame handed from front to back
  typedef struct packed {
    logic [15:0] temp_word;
    logic [15:0] humi_word;
    logic        good;
  } job_t;

  // queue status seen by the front and the back
  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  // one byte through the crc, msb first
  function automatic logic [7:0] crc_feed(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

[rtl/thfd_in_if.sv]
interface thfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       frame_start;

  modport source (output valid, output rx_byte, output frame_start, input ready);
  modport sink   (input valid, input rx_byte, input frame_start, output ready);
endinterface

[rtl/thfd_out_if.sv]
interface thfd_out_if;
  logic               valid;
  logic               ready;
  logic signed [14:0] temperature_centi;
  logic [13:0]        humidity_centi;
  logic               status;

  modport source (output valid, output temperature_centi, output humidity_centi,
                  output status, input ready);
  modport sink   (input valid, input temperature_centi, input humidity_centi,
                  input status, output ready);
endinterface

[rtl/thfd_front.sv]
module thfd_front
  import thfd_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  thfd_in_if.sink       in_ch,
  input  queue_status_t q_status,
  output logic          push,
  output job_t          push_job
);

  logic [2:0] byte_count;
  logic [7:0] crc_running;
  logic [7:0] word_high;
  logic [15:0] temp_word;
  logic        temp_crc_good;
  logic [15:0] humi_word;

  logic [2:0] pos;
  logic       accept;
  logic [7:0] crc_feed_out;
  logic       crc_match;

  // take a word whenever the queue can hold a finished frame
  assign in_ch.ready = !q_status.full;
  assign accept      = in_ch.valid && in_ch.ready;

  // frame position, resynchronised by frame_start
  always_comb begin
    if (in_ch.frame_start || byte_count > POS_HUMI_CRC) begin
      pos = POS_TEMP_HI;
    end else begin
      pos = byte_count;
    end
  end

  // crc of the next word, restarting at the high word of each pair
  always_comb begin
    if (pos == POS_TEMP_HI || pos == POS_HUMI_HI) begin
      crc_feed_out = crc_feed(CRC_INIT, in_ch.rx_byte);
    end else begin
      crc_feed_out = crc_feed(crc_running, in_ch.rx_byte);
    end
  end

  assign crc_match = (crc_running == in_ch.rx_byte);

  // frame complete: hand it to the back
  assign push               = accept && (pos == POS_HUMI_CRC);
  assign push_job.temp_word = temp_word;
  assign push_job.humi_word = humi_word;
  assign push_job.good      = temp_crc_good && crc_match;

  // frame assembly state
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count    <= POS_TEMP_HI;
      crc_running   <= CRC_INIT;
      word_high     <= '0;
      temp_word     <= '0;
      temp_crc_good <= 1'b0;
      humi_word     <= '0;
    end else if (accept) begin
      unique case (pos)
        POS_TEMP_HI, POS_HUMI_HI: begin
          word_high   <= in_ch.rx_byte;
          crc_running <= crc_feed_out;
          byte_count  <= pos + 3'd1;
        end
        POS_TEMP_LO: begin
          temp_word   <= {word_high, in_ch.rx_byte};
          crc_running <= crc_feed_out;
          byte_count  <= pos + 3'd1;
        end
        POS_HUMI_LO: begin
          humi_word   <= {word_high, in_ch.rx_byte};
          crc_running <= crc_feed_out;
          byte_count  <= pos + 3'd1;
        end
        POS_TEMP_CRC: begin
          temp_crc_good <= crc_match;
          crc_running   <= CRC_INIT;
          byte_count    <= pos + 3'd1;
        end
        default: begin
          crc_running <= CRC_INIT;
          byte_count  <= POS_TEMP_HI;
        end
      endcase
    end
  end

endmodule

[rtl/thfd_queue.sv]
module thfd_queue
  import thfd_pkg::*;
#(
  parameter int QueueDepth = QUEUE_DEPTH_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  job_t          push_job,
  input  logic          pop,
  output job_t          pop_job,
  output queue_status_t q_status
);

  localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntW = $clog2(QueueDepth + 1);

  job_t            entries [QueueDepth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign q_status.full  = (count == CntW'(QueueDepth));
  assign q_status.empty = (count == '0);
  assign pop_job        = entries[rd_ptr];

  // storage, written at the tail
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr + PtrW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr + PtrW'(1);
      end
      if (push && !pop) begin
        count <= count + CntW'(1);
      end else if (pop && !push) begin
        count <= count - CntW'(1);
      end
    end
  end

endmodule

[rtl/thfd_back.sv]
module thfd_back
  import thfd_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  queue_status_t q_status,
  input  job_t          pop_job,
  output logic          pop,
  thfd_out_if.source    out_ch
);

  logic advance;

  // stage 1: products
  logic        s1_valid;
  logic [30:0] s1_temp_prod;
  logic [29:0] s1_humi_prod;
  logic        s1_good;

  // stage 2: offset removed, sign split off
  logic        s2_valid;
  logic        s2_neg;
  logic [29:0] s2_temp_mag;
  logic [29:0] s2_humi_prod;
  logic        s2_good;
  logic signed [31:0] temp_diff;

  // stage 3: quotient estimate and remainder for divide by 65535
  logic        s3_valid;
  logic        s3_neg;
  logic [13:0] s3_temp_q;
  logic [16:0] s3_temp_r;
  logic [13:0] s3_humi_q;
  logic [16:0] s3_humi_r;
  logic        s3_good;

  logic [14:0] temp_quot;
  logic [13:0] humi_quot;

  // the whole pipe moves unless a result is held at the output
  assign advance = !out_ch.valid || out_ch.ready;
  assign pop     = advance && !q_status.empty;

  assign temp_diff = $signed({1'b0, s1_temp_prod}) - TEMP_OFFSET;

  // final correction: remainder is below twice the divisor
  assign temp_quot = 15'(s3_temp_q) + 15'(s3_temp_r >= FULL_SCALE);
  assign humi_quot = s3_humi_q + 14'(s3_humi_r >= FULL_SCALE);

  // stage valid flags and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
      s3_valid     <= 1'b0;
      out_ch.valid <= 1'b0;
    end else if (advance) begin
      s1_valid     <= pop;
      s2_valid     <= s1_valid;
      s3_valid     <= s2_valid;
      out_ch.valid <= s3_valid;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (advance) begin
      s1_temp_prod <= 31'(pop_job.temp_word) * 31'(TEMP_GAIN);
      s1_humi_prod <= 30'(pop_job.humi_word) * 30'(HUMI_GAIN);
      s1_good      <= pop_job.good;

      s2_neg       <= temp_diff[31];
      s2_temp_mag  <= temp_diff[31] ? 30'(-temp_diff) : 30'(temp_diff);
      s2_humi_prod <= s1_humi_prod;
      s2_good      <= s1_good;

      s3_neg    <= s2_neg;
      s3_temp_q <= s2_temp_mag[29:16];
      s3_temp_r <= {1'b0, s2_temp_mag[15:0]} + 17'(s2_temp_mag[29:16]);
      s3_humi_q <= s2_humi_prod[29:16];
      s3_humi_r <= {1'b0, s2_humi_prod[15:0]} + 17'(s2_humi_prod[29:16]);
      s3_good   <= s2_good;

      if (s3_valid) begin
        if (s3_good) begin
          out_ch.temperature_centi <= s3_neg ? $signed(-temp_quot) : $signed(temp_quot);
          out_ch.humidity_centi    <= humi_quot;
          out_ch.status            <= 1'b0;
        end else begin
          out_ch.temperature_centi <= '0;
          out_ch.humidity_centi    <= '0;
          out_ch.status            <= 1'b1;
        end
      end
    end
  end

endmodule

[rtl/temp_humidity_frame_decoder.sv]
// Sensor frame decoder: checks and scales one temperature/humidity measurement.
// in_ch carries one frame word per transfer, in the order temperature high,
// temperature low, temperature crc, humidity high, humidity low, humidity crc.
// frame_start high marks a word as the temperature high word and resyncs the count.
// out_ch carries one result per frame: temperature and humidity in hundredths,
// and status 1 (with both values zero) when either crc-8 (0x31, init 0xff) fails.
// Throughput: one input word per cycle. The front takes a word every cycle
// while the frame queue has room; only a full queue drops in_ch.ready.
// The edge that takes the sixth word writes the queue; the frame then passes
// through the three pipeline stages in the back and the output register.
// The back is a three-stage pipeline (constant multiply, offset and sign,
// divide by 65535 via shift-add and one correction) that handles one frame a cycle
// while out_ch is not stalled. When out_ch is stalled the back pipe freezes, the
// queue fills, and with QueueDepth frames waiting the input stalls too; nothing is lost.
// Reset (rst, synchronous) empties the queue and pipe and restarts the count
// at the temperature high word.
module temp_humidity_frame_decoder
  import thfd_pkg::*;
#(
  parameter int QueueDepth = QUEUE_DEPTH_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  thfd_in_if.sink    in_ch,
  thfd_out_if.source out_ch
);

  logic          push;
  job_t          push_job;
  logic          pop;
  job_t          pop_job;
  queue_status_t q_status;

  // front: frame assembly and crc check
  thfd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_ch    (in_ch),
    .q_status (q_status),
    .push     (push),
    .push_job (push_job)
  );

  // queue of finished frames
  thfd_queue #(
    .QueueDepth (QueueDepth)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .pop_job  (pop_job),
    .q_status (q_status)
  );

  // back: scaling pipeline and output register
  thfd_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_status (q_status),
    .pop_job  (pop_job),
    .pop      (pop),
    .out_ch   (out_ch)
  );

  // a finished frame never meets a full queue
  assert property (@(posedge clk) disable iff (rst) !(push && q_status.full))
    else $error("frame pushed into full queue");

  // the back never pops an empty queue
  assert property (@(posedge clk) disable iff (rst) !(pop && q_status.empty))
    else $error("pop from empty queue");

  // a failed frame carries zero values
  assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.status |->
      out_ch.temperature_centi == '0 && out_ch.humidity_centi == '0)
    else $error("crc failure with nonzero values");

  // humidity stays within full scale
  assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> out_ch.humidity_centi <= 14'd10000)
    else $error("humidity above full scale");

endmodule
